@@ design/hnp_pkg.sv @@
package hnp_pkg;

  // search limits and arithmetic depth
  localparam int MAX_CANDIDATES = 256;
  localparam int CORDIC_STEPS   = 24;
  localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
  localparam logic [7:0] RUN_SAT =
    8'(((MAX_CANDIDATES - 1) < 255) ? (MAX_CANDIDATES - 1) : 255);

  // field widths
  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DIST_W = 25;
  localparam int IDX_W  = 8;

  // configuration register indexes
  localparam logic CFG_ORIGIN_LAT = 1'b0;
  localparam logic CFG_ORIGIN_LON = 1'b1;

  // fixed point constants
  localparam logic [31:0] RECIP45_HI  = 32'd3054198967;  // ceil(2^37 / 45)
  localparam logic [25:0] RECIP45_LO  = 26'd47721859;    // ceil(2^31 / 45)
  localparam logic [16:0] CIRC_HI     = 17'd78183;       // circumference*256 >> 17
  localparam logic [16:0] CIRC_LO     = 17'd122264;      // low 17 bits of it
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic signed [34:0] INV_GAIN = 35'sd652032874;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CONV_Q,
    ST_CONV_F,
    ST_CONV_T,
    ST_ROT,
    ST_ROT_WAIT,
    ST_MUL_SDL,
    ST_MUL_SDO,
    ST_MUL_COS,
    ST_MUL_HAV,
    ST_SUM_A,
    ST_SQY_GO,
    ST_SQY,
    ST_SQX_GO,
    ST_SQX,
    ST_VEC_GO,
    ST_VEC,
    ST_DIST_HI,
    ST_DIST_LO,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // control into the cordic unit
  typedef struct packed {
    logic start;
    logic vec;
  } cordic_ctl_t;

  // arctangent of 2^-i as binary angle, 2^32 per turn
  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      5'd30: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ design/hnp_mul.sv @@
module hnp_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p_r
);

  // shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

@@ design/hnp_cordic.sv @@
module hnp_cordic (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hnp_pkg::cordic_ctl_t      ctl,
  input  logic [31:0]               ang,
  input  logic [30:0]               xi,
  input  logic [30:0]               yi,
  output logic                      done_r,
  output logic signed [31:0]        xo,
  output logic signed [31:0]        yo,
  output logic signed [34:0]        zo
);
  import hnp_pkg::*;

  logic               busy_r;
  logic [4:0]         i_r;
  logic               vec_r;
  logic               neg_r;
  logic signed [34:0] x_r, y_r, z_r;
  logic signed [34:0] dx, dy, at;
  logic               turn_neg;
  logic [31:0]        fold_chk, ang_f;
  logic signed [34:0] x_neg, y_neg;

  // fold angle into [-90, 90) degrees
  assign fold_chk = ang + 32'h4000_0000;
  assign ang_f    = fold_chk[31] ? (ang + 32'h8000_0000) : ang;

  // one micro-rotation per cycle
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = $signed({5'b0, atan_lut(i_r)});
  assign turn_neg = vec_r ? !y_r[34] : z_r[34];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        i_r    <= 5'd0;
      end else if (busy_r) begin
        if (i_r == CORDIC_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          i_r <= i_r + 5'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      vec_r <= ctl.vec;
      if (ctl.vec) begin
        neg_r <= 1'b0;
        x_r   <= $signed({4'b0, xi});
        y_r   <= $signed({4'b0, yi});
        z_r   <= '0;
      end else begin
        neg_r <= fold_chk[31];
        x_r   <= INV_GAIN;
        y_r   <= '0;
        z_r   <= $signed({{3{ang_f[31]}}, ang_f});
      end
    end else if (busy_r) begin
      if (turn_neg) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end
    end
  end

  // undo the half-turn fold
  assign x_neg = neg_r ? -x_r : x_r;
  assign y_neg = neg_r ? -y_r : y_r;
  assign xo = x_neg[31:0];
  assign yo = y_neg[31:0];
  assign zo = z_r;

endmodule

@@ design/hnp_isqrt.sv @@
module hnp_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [60:0] v_in,
  output logic        done_r,
  output logic [30:0] root
);

  logic        busy_r;
  logic [4:0]  k_r;
  logic [61:0] v_r, r_r;
  logic [61:0] bitv, trial;
  logic        take;

  // one result bit per cycle, bit = 4^k
  assign bitv  = 62'(1) << {k_r, 1'b0};
  assign trial = r_r + bitv;
  assign take  = (v_r >= trial);
  assign root  = r_r[30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= 5'd30;
      end else if (busy_r) begin
        if (k_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          k_r <= k_r - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= {1'b0, v_in};
      r_r <= '0;
    end else if (busy_r) begin
      if (take) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bitv;
      end else begin
        r_r <= r_r >> 1;
      end
    end
  end

endmodule

@@ design/haversine_nearest_point_core.sv @@
// channel   | handshake          | payload
// in        | in_valid/in_stall  | candidate_latitude, candidate_longitude, last_candidate
// out       | out_valid/out_stall| nearest_latitude, nearest_longitude, nearest_index,
//           |                    |   nearest_distance_m
// cfg       | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a candidate's scoring, from its transfer to the next idle state, is paced by the shared
// cordic unit (four rotations and one vectoring pass, one step a cycle) and the square-root
// unit (two roots of 31 steps each); the last of a run also passes through the emit state
// in_stall is high from a transfer until the candidate is fully scored and, for the last of a run, its result is taken
// reset (rst_n low, synchronous) clears the search and zeroes the origin
// a result waiting under out_stall holds the sequencer in the emit state, so the next candidate waits
module haversine_nearest_point_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [hnp_pkg::LAT_W-1:0]  in_candidate_latitude,
  input  logic signed [hnp_pkg::LON_W-1:0]  in_candidate_longitude,
  input  logic                              in_last_candidate,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hnp_pkg::LAT_W-1:0]  out_nearest_latitude,
  output logic signed [hnp_pkg::LON_W-1:0]  out_nearest_longitude,
  output logic [hnp_pkg::IDX_W-1:0]         out_nearest_index,
  output logic [hnp_pkg::DIST_W-1:0]        out_nearest_distance_m,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [hnp_pkg::LON_W-1:0]         cfg_data
);
  import hnp_pkg::*;

  state_t state_r, state_nxt;

  logic [LAT_W-1:0]  org_lat_r;
  logic [LON_W-1:0]  org_lon_r;
  logic [LAT_W-1:0]  cand_lat_r;
  logic [LON_W-1:0]  cand_lon_r;
  logic              cand_last_r;
  logic [1:0]        j_r;

  logic [DIST_W-1:0] best_dist_r;
  logic [LAT_W-1:0]  best_lat_r;
  logic [LON_W-1:0]  best_lon_r;
  logic [IDX_W-1:0]  best_pos_r;
  logic [IDX_W-1:0]  run_cnt_r;

  logic              out_valid_r;
  logic [LAT_W-1:0]  out_lat_r;
  logic [LON_W-1:0]  out_lon_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [DIST_W-1:0] out_dist_r;

  logic [20:0]        q0_r;
  logic [31:0]        ang_r;
  logic signed [31:0] sdl_r, sdo_r, c1_r, c2_r;
  logic signed [32:0] a1_r, so_r;
  logic [30:0]        a_r, y0_r, x0_r, z_r;
  logic [47:0]        hi_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;

  cordic_ctl_t        cor_ctl;
  logic               cor_done;
  logic signed [31:0] cor_x, cor_y;
  logic signed [34:0] cor_z;

  logic               sq_start;
  logic [60:0]        sq_in;
  logic               sq_done;
  logic [30:0]        sq_root;

  logic               emit_load;
  logic               accept;

  logic [25:0]        conv_v, conv_u;
  logic               conv_neg, conv_k13;
  logic [20:0]        q0_now;
  logic [25:0]        r0_full;
  logic [5:0]         r0;
  logic [18:0]        conv_n;
  logic [31:0]        conv_t, conv_ang;
  logic signed [33:0] a_sum;
  logic [30:0]        a_clamp;
  logic [30:0]        z_clamp;
  logic [64:0]        dist_sum;
  logic [DIST_W-1:0]  dist_m;

  // units
  hnp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  hnp_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cor_ctl),
    .ang    (ang_r),
    .xi     (x0_r),
    .yi     (y0_r),
    .done_r (cor_done),
    .xo     (cor_x),
    .yo     (cor_y),
    .zo     (cor_z)
  );

  hnp_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .v_in   (sq_in),
    .done_r (sq_done),
    .root   (sq_root)
  );

  assign accept = in_valid && !in_stall;

  // angle to convert: half deltas, then full latitudes
  always_comb begin
    case (j_r)
      2'd0:    conv_v = 26'($signed(cand_lat_r)) - 26'($signed(org_lat_r));
      2'd1:    conv_v = 26'($signed(cand_lon_r)) - 26'($signed(org_lon_r));
      2'd2:    conv_v = 26'($signed(org_lat_r));
      default: conv_v = 26'($signed(cand_lat_r));
    endcase
  end

  // v*2^k/45 toward zero by reciprocal multiplies, mod one turn
  assign conv_neg = conv_v[25];
  assign conv_k13 = j_r[1];
  assign conv_u   = conv_neg ? (~conv_v + 26'd1) : conv_v;
  assign q0_now   = prod_r[57:37];
  assign r0_full  = conv_u - 26'(q0_now * 26'd45);
  assign r0       = r0_full[5:0];
  assign conv_n   = conv_k13 ? {r0, 13'b0} : {1'b0, r0, 12'b0};
  assign conv_t   = (conv_k13 ? 32'({q0_r, 13'b0}) : 32'({q0_r, 12'b0}))
                  + 32'(prod_r[43:31]);
  assign conv_ang = conv_neg ? (~conv_t + 32'd1) : conv_t;

  // haversine term, clamped to [0, 1]
  assign a_sum = 34'(a1_r) + 34'($signed(prod_r[62:30]));
  always_comb begin
    if (a_sum[33])
      a_clamp = '0;
    else if (a_sum > 34'sd1073741824)
      a_clamp = ONE_Q30;
    else
      a_clamp = a_sum[30:0];
  end

  // central angle clamp
  always_comb begin
    if (cor_z[34])
      z_clamp = '0;
    else if (cor_z > 35'sd1073741824)
      z_clamp = ONE_Q30;
    else
      z_clamp = cor_z[30:0];
  end

  // distance in metres, rounded
  assign dist_sum = {hi_r, 17'b0} + 65'(prod_r[47:0]) + (65'(1) << 38);
  assign dist_m   = dist_sum[63:39];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_CONV_Q;
      ST_CONV_Q:   state_nxt = ST_CONV_F;
      ST_CONV_F:   state_nxt = ST_CONV_T;
      ST_CONV_T:   state_nxt = ST_ROT;
      ST_ROT:      state_nxt = ST_ROT_WAIT;
      ST_ROT_WAIT: if (cor_done) state_nxt = (j_r == 2'd3) ? ST_MUL_SDL : ST_CONV_Q;
      ST_MUL_SDL:  state_nxt = ST_MUL_SDO;
      ST_MUL_SDO:  state_nxt = ST_MUL_COS;
      ST_MUL_COS:  state_nxt = ST_MUL_HAV;
      ST_MUL_HAV:  state_nxt = ST_SUM_A;
      ST_SUM_A:    state_nxt = ST_SQY_GO;
      ST_SQY_GO:   state_nxt = ST_SQY;
      ST_SQY:      if (sq_done) state_nxt = ST_SQX_GO;
      ST_SQX_GO:   state_nxt = ST_SQX;
      ST_SQX:      if (sq_done) state_nxt = ST_VEC_GO;
      ST_VEC_GO:   state_nxt = ST_VEC;
      ST_VEC:      if (cor_done) state_nxt = ST_DIST_HI;
      ST_DIST_HI:  state_nxt = ST_DIST_LO;
      ST_DIST_LO:  state_nxt = ST_UPDATE;
      ST_UPDATE:   state_nxt = cand_last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT:     if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: operand selection, unit starts, input stall and result load
  always_comb begin
    in_stall      = 1'b1;
    cor_ctl.start = 1'b0;
    cor_ctl.vec   = 1'b0;
    sq_start      = 1'b0;
    sq_in         = {a_r, 30'b0};
    emit_load     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state_r)
      ST_IDLE:    in_stall = 1'b0;
      ST_CONV_Q: begin
        mul_a = $signed({7'b0, conv_u});
        mul_b = $signed({1'b0, RECIP45_HI});
      end
      ST_CONV_F: begin
        mul_a = $signed({14'b0, conv_n});
        mul_b = $signed({7'b0, RECIP45_LO});
      end
      ST_ROT:     cor_ctl.start = 1'b1;
      ST_MUL_SDL: begin
        mul_a = 33'(sdl_r);
        mul_b = 33'(sdl_r);
      end
      ST_MUL_SDO: begin
        mul_a = 33'(sdo_r);
        mul_b = 33'(sdo_r);
      end
      ST_MUL_COS: begin
        mul_a = 33'(c1_r);
        mul_b = 33'(c2_r);
      end
      ST_MUL_HAV: begin
        mul_a = $signed(prod_r[62:30]);
        mul_b = so_r;
      end
      ST_SQY_GO:  sq_start = 1'b1;
      ST_SQX_GO: begin
        sq_start = 1'b1;
        sq_in    = {ONE_Q30 - a_r, 30'b0};
      end
      ST_VEC_GO: begin
        cor_ctl.start = 1'b1;
        cor_ctl.vec   = 1'b1;
      end
      ST_DIST_HI: begin
        mul_a = $signed({2'b0, z_r});
        mul_b = $signed({16'b0, CIRC_HI});
      end
      ST_DIST_LO: begin
        mul_a = $signed({2'b0, z_r});
        mul_b = $signed({16'b0, CIRC_LO});
      end
      ST_EMIT:    emit_load = !out_valid_r || !out_stall;
      default:    in_stall = 1'b1;
    endcase
  end

  // state and angle counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      j_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (accept)
        j_r <= 2'd0;
      else if (state_r == ST_ROT_WAIT && cor_done)
        j_r <= j_r + 2'd1;
    end
  end

  // configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_lat_r <= '0;
      org_lon_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_LAT: org_lat_r <= cfg_data[LAT_W-1:0];
        CFG_ORIGIN_LON: org_lon_r <= cfg_data;
        default:        org_lat_r <= org_lat_r;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cand_lat_r  <= in_candidate_latitude;
      cand_lon_r  <= in_candidate_longitude;
      cand_last_r <= in_last_candidate;
    end
    case (state_r)
      ST_CONV_F:   q0_r <= q0_now;
      ST_CONV_T:   ang_r <= conv_ang;
      ST_ROT_WAIT: begin
        if (cor_done) begin
          case (j_r)
            2'd0:    sdl_r <= cor_y;
            2'd1:    sdo_r <= cor_y;
            2'd2:    c1_r  <= cor_x;
            default: c2_r  <= cor_x;
          endcase
        end
      end
      ST_MUL_SDO:  a1_r <= $signed(prod_r[62:30]);
      ST_MUL_COS:  so_r <= $signed(prod_r[62:30]);
      ST_SUM_A:    a_r  <= a_clamp;
      ST_SQY:      if (sq_done) y0_r <= sq_root;
      ST_SQX:      if (sq_done) x0_r <= sq_root;
      ST_VEC:      if (cor_done) z_r <= z_clamp;
      ST_DIST_LO:  hi_r <= prod_r[47:0];
      default:     q0_r <= q0_r;
    endcase
  end

  // best candidate so far
  always_ff @(posedge clk) begin
    if (!rst_n || emit_load) begin
      best_dist_r <= '1;
      best_lat_r  <= '0;
      best_lon_r  <= '0;
      best_pos_r  <= '0;
      run_cnt_r   <= '0;
    end else if (state_r == ST_UPDATE) begin
      if (dist_m < best_dist_r) begin
        best_dist_r <= dist_m;
        best_lat_r  <= cand_lat_r;
        best_lon_r  <= cand_lon_r;
        best_pos_r  <= run_cnt_r;
      end
      if (run_cnt_r < RUN_SAT)
        run_cnt_r <= run_cnt_r + 8'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (emit_load)
      out_valid_r <= 1'b1;
    else if (!out_stall)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_lat_r  <= best_lat_r;
      out_lon_r  <= best_lon_r;
      out_idx_r  <= best_pos_r;
      out_dist_r <= best_dist_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_nearest_latitude   = out_lat_r;
  assign out_nearest_longitude  = out_lon_r;
  assign out_nearest_index      = out_idx_r;
  assign out_nearest_distance_m = out_dist_r;

  // checks
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input taken while a candidate is being scored");

  a_best_never_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |=> (best_dist_r <= $past(best_dist_r)))
    else $error("best distance grew within a run");

  a_index_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    run_cnt_r <= RUN_SAT)
    else $error("run counter past saturation");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside the emit step");

endmodule
